FILE: sv/qau_pkg.sv
// Quaternion arithmetic unit package: widths, transaction types, op decode
// codes, Hamilton term table and the rounding/saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package qau_pkg;

	localparam int CW    = 32;            // component width
	localparam int FB    = 16;            // fraction bits
	localparam int PW    = 2 * CW;        // one product
	localparam int ACC_W = 2 * CW + 2;    // sum of four products, with headroom
	localparam int SQ_W  = 2 * CW + 1;    // sum of four squares, unsigned
	localparam int QD    = 2;             // depth of the front queue

	localparam logic [2:0] KIND_MUL  = 3'd0;
	localparam logic [2:0] KIND_ADD  = 3'd1;
	localparam logic [2:0] KIND_SUB  = 3'd2;
	localparam logic [2:0] KIND_NEG  = 3'd3;
	localparam logic [2:0] KIND_CONJ = 3'd4;
	localparam logic [2:0] KIND_ROT  = 3'd5;
	localparam logic [2:0] KIND_NSQ  = 3'd6;
	localparam logic [2:0] KIND_NORM = 3'd7;

	// Term t of component c is p[t] * q[t ^ c]; bit c*4+t set means subtract.
	localparam logic [15:0] TERM_NEG = 16'b0100_0010_1000_1110;

	typedef logic [CW-1:0] comp_t;
	typedef comp_t [3:0] quat_t;          // index 0 is w, then x, y, z

	typedef struct packed {
		logic [2:0] kind;
		comp_t a_w;
		comp_t a_x;
		comp_t a_y;
		comp_t a_z;
		comp_t b_w;
		comp_t b_x;
		comp_t b_y;
		comp_t b_z;
	} in_t;

	typedef struct packed {
		comp_t r_w;
		comp_t r_x;
		comp_t r_y;
		comp_t r_z;
		logic  overflow;
	} out_t;

	typedef struct packed {
		logic mul;
		logic add;
		logic sub;
		logic neg;
		logic conj;
		logic rot;
		logic nsq;
		logic norm;
	} op_t;

	typedef struct packed {
		op_t   op;
		quat_t a;
		quat_t b;
	} item_t;

	localparam comp_t COMP_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam comp_t COMP_MIN = {1'b1, {(CW-1){1'b0}}};

	// Saturate a wide signed value: returns {overflow, component}.
	function automatic logic [CW:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-CW:0] top;
		logic [CW:0] r;
		top = v[ACC_W-1:CW-1];
		if (top == '0 || top == '1)
			r = {1'b0, v[CW-1:0]};
		else if (v[ACC_W-1])
			r = {1'b1, COMP_MIN};
		else
			r = {1'b1, COMP_MAX};
		return r;
	endfunction

	// Round half up to FB fraction bits, then saturate.
	function automatic logic [CW:0] round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + (ACC_W'(1) <<< (FB - 1));
		t = t >>> FB;
		return sat_acc(t);
	endfunction

	// Saturate a sum of two components.
	function automatic logic [CW:0] sat_sum(input logic signed [CW:0] v);
		logic [CW:0] r;
		if (v[CW] == v[CW-1])
			r = {1'b0, v[CW-1:0]};
		else if (v[CW])
			r = {1'b1, COMP_MIN};
		else
			r = {1'b1, COMP_MAX};
		return r;
	endfunction

endpackage

FILE: sv/qau_front.sv
// Front end: takes operand transactions, decodes the operation code and holds
// them in a short queue for the back end. Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  qau_pkg::in_t   operand,
	output logic           head_valid,
	output qau_pkg::item_t head,
	input  logic           take
);

	localparam int PTR_W = $clog2(qau_pkg::QD);

	qau_pkg::item_t          queue_q [qau_pkg::QD];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [PTR_W:0]          count_q;
	qau_pkg::item_t          item;
	logic                    do_push;
	logic                    do_pop;

	always_comb begin
		item.op = '0;
		unique case (operand.kind)
			qau_pkg::KIND_MUL:  item.op.mul  = 1'b1;
			qau_pkg::KIND_ADD:  item.op.add  = 1'b1;
			qau_pkg::KIND_SUB:  item.op.sub  = 1'b1;
			qau_pkg::KIND_NEG:  item.op.neg  = 1'b1;
			qau_pkg::KIND_CONJ: item.op.conj = 1'b1;
			qau_pkg::KIND_ROT:  item.op.rot  = 1'b1;
			qau_pkg::KIND_NSQ:  item.op.nsq  = 1'b1;
			qau_pkg::KIND_NORM: item.op.norm = 1'b1;
			default:            item.op      = '0;
		endcase
		item.a = {operand.a_z, operand.a_y, operand.a_x, operand.a_w};
		item.b = {operand.b_z, operand.b_y, operand.b_x, operand.b_w};
	end

	assign full       = (count_q == (PTR_W+1)'(qau_pkg::QD));
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = take && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) queue_q[wr_ptr_q] <= item;
	end

endmodule

FILE: sv/qau_back.sv
// Back end: product, sum/round and square-root pipeline with a single
// stall enable; its last stage is the result register. Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  qau_pkg::item_t head,
	output logic           take,
	input  logic           pop,
	output logic           empty,
	output qau_pkg::out_t  result
);

	localparam int CW = qau_pkg::CW;
	localparam int NS = qau_pkg::CW;      // one root bit per stage

	typedef logic signed [qau_pkg::PW-1:0] prod_t;
	typedef prod_t [3:0][3:0] prods_t;

	typedef struct packed {
		logic                      norm;
		qau_pkg::out_t             res;
		logic [qau_pkg::SQ_W-1:0]  rem;
		logic [CW-1:0]             root;
	} sq_t;

	logic en;

	// stage 1
	logic            v_s1;
	qau_pkg::op_t    op_s1;
	qau_pkg::quat_t  a_s1;
	prods_t          p_s1;
	qau_pkg::out_t   res_s1;
	// stage 2
	logic            v_s2;
	qau_pkg::op_t    op_s2;
	qau_pkg::quat_t  a_s2;
	qau_pkg::quat_t  t_s2;
	qau_pkg::out_t   res_s2;
	logic [qau_pkg::SQ_W-1:0] ssum_s2;
	// stage 3
	logic            v_s3;
	qau_pkg::op_t    op_s3;
	prods_t          p_s3;
	qau_pkg::out_t   res_s3;
	logic [qau_pkg::SQ_W-1:0] ssum_s3;
	// stage 4 and root chain
	logic            sq_v_s [NS+1];
	sq_t             sq_s   [NS+1];

	qau_pkg::quat_t  q1;
	prods_t          p1;
	qau_pkg::out_t   simple;
	qau_pkg::quat_t  t2;
	logic            t2_ovf;
	logic [qau_pkg::SQ_W-1:0] ssum2;
	logic [CW:0]     nsq2;
	prods_t          p3;
	qau_pkg::quat_t  r4;
	logic            r4_ovf;

	assign en    = !sq_v_s[NS] || pop;
	assign take  = en;
	assign empty = !sq_v_s[NS];

	function automatic logic signed [CW:0] sat_in(input qau_pkg::comp_t x);
		return $signed({x[CW-1], x});
	endfunction

	// stage 1: first set of products and the exact-before-saturation ops
	always_comb begin
		logic [CW:0] s;
		logic [1:0]  j;
		if (head.op.nsq || head.op.norm)
			q1 = head.a;
		else if (head.op.rot)
			q1 = {head.b[3], head.b[2], head.b[1], {CW{1'b0}}};
		else
			q1 = head.b;
		for (int c = 0; c < 4; c++) begin
			for (int t = 0; t < 4; t++) begin
				j = 2'(t ^ c);
				p1[c][t] = $signed(head.a[t]) * $signed(q1[j]);
			end
		end
		simple = '0;
		for (int i = 0; i < 4; i++) begin
			if (head.op.add)
				s = sat_in(head.a[i]) + sat_in(head.b[i]);
			else if (head.op.sub)
				s = sat_in(head.a[i]) - sat_in(head.b[i]);
			else if (head.op.neg || (head.op.conj && i > 0))
				s = -sat_in(head.a[i]);
			else
				s = sat_in(head.a[i]);
			s = qau_pkg::sat_sum($signed(s));
			simple.overflow = simple.overflow | s[CW];
			unique case (i)
				0: simple.r_w = s[CW-1:0];
				1: simple.r_x = s[CW-1:0];
				2: simple.r_y = s[CW-1:0];
				default: simple.r_z = s[CW-1:0];
			endcase
		end
	end

	function automatic logic [CW:0] sum_terms(input prod_t [3:0] p, input logic [3:0] neg);
		logic signed [qau_pkg::ACC_W-1:0] acc;
		logic signed [qau_pkg::ACC_W-1:0] term;
		acc = '0;
		for (int t = 0; t < 4; t++) begin
			term = $signed({{2{p[t][qau_pkg::PW-1]}}, p[t]});
			acc = neg[t] ? acc - term : acc + term;
		end
		return qau_pkg::round_sat(acc);
	endfunction

	// stage 2: first Hamilton sums, squared norm
	always_comb begin
		logic [CW:0] r;
		t2_ovf = 1'b0;
		for (int c = 0; c < 4; c++) begin
			r = sum_terms(p_s1[c], qau_pkg::TERM_NEG[c*4 +: 4]);
			t2[c]  = r[CW-1:0];
			t2_ovf = t2_ovf | r[CW];
		end
		ssum2 = '0;
		for (int t = 0; t < 4; t++)
			ssum2 = ssum2 + qau_pkg::SQ_W'(p_s1[0][t][qau_pkg::PW-1:0]);
		nsq2 = qau_pkg::round_sat($signed(qau_pkg::ACC_W'(ssum2)));
	end

	// stage 3: products T * conj(A)
	always_comb begin
		logic [1:0] j;
		for (int c = 0; c < 4; c++) begin
			for (int t = 0; t < 4; t++) begin
				j = 2'(t ^ c);
				p3[c][t] = $signed(t_s2[t]) * $signed(a_s2[j]);
			end
		end
	end

	// stage 4: second Hamilton sums, conjugate flips the sign of vector terms
	always_comb begin
		logic [CW:0] r;
		logic [3:0]  neg;
		r4_ovf = 1'b0;
		for (int c = 0; c < 4; c++) begin
			for (int t = 0; t < 4; t++)
				neg[t] = qau_pkg::TERM_NEG[c*4 + t] ^ ((t ^ c) != 0);
			r = sum_terms(p_s3[c], neg);
			r4[c]  = r[CW-1:0];
			r4_ovf = r4_ovf | r[CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= head.op;
			a_s1   <= head.a;
			p_s1   <= p1;
			res_s1 <= simple;

			op_s2   <= op_s1;
			a_s2    <= a_s1;
			t_s2    <= t2;
			ssum_s2 <= ssum2;
			if (op_s1.mul) begin
				res_s2 <= {t2[0], t2[1], t2[2], t2[3], t2_ovf};
			end else if (op_s1.nsq) begin
				res_s2 <= {nsq2[CW-1:0], {(3*CW){1'b0}}, nsq2[CW]};
			end else if (op_s1.rot) begin
				res_s2 <= {res_s1.r_w, res_s1.r_x, res_s1.r_y, res_s1.r_z, t2_ovf};
			end else begin
				res_s2 <= res_s1;
			end

			op_s3   <= op_s2;
			p_s3    <= p3;
			ssum_s3 <= ssum_s2;
			res_s3  <= res_s2;
		end
	end

	// stage 4 enters the root chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (en) sq_v_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].norm <= op_s3.norm;
			sq_s[0].rem  <= ssum_s3;
			sq_s[0].root <= '0;
			if (op_s3.rot)
				sq_s[0].res <= {{CW{1'b0}}, r4[1], r4[2], r4[3],
					res_s3.overflow | r4_ovf};
			else if (op_s3.norm)
				sq_s[0].res <= '0;
			else
				sq_s[0].res <= res_s3;
		end
	end

	// restoring square root, one result bit per stage, MSB first
	for (genvar k = 0; k < NS; k++) begin : g_root
		localparam int BIT = CW - 1 - k;
		logic [qau_pkg::SQ_W-1:0] delta;
		logic                     fits;
		logic [CW-1:0]            root_n;
		logic [qau_pkg::SQ_W-1:0] rem_n;

		assign delta  = (qau_pkg::SQ_W'(sq_s[k].root) << (BIT + 1))
			| (qau_pkg::SQ_W'(1) << (2 * BIT));
		assign fits   = (sq_s[k].rem >= delta);
		assign root_n = fits ? (sq_s[k].root | (CW'(1) << BIT)) : sq_s[k].root;
		assign rem_n  = fits ? sq_s[k].rem - delta : sq_s[k].rem;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else if (en) sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= {sq_s[k].norm, sq_s[k].res, rem_n, root_n};
			end
		end
	end

	always_comb begin
		result = sq_s[NS].res;
		if (sq_s[NS].norm) begin
			if (sq_s[NS].root[CW-1]) begin
				result.r_w      = qau_pkg::COMP_MAX;
				result.overflow = 1'b1;
			end else begin
				result.r_w = sq_s[NS].root;
			end
		end
	end

endmodule

FILE: sv/quaternion_arithmetic_unit_core.sv
// Quaternion arithmetic unit, top level: Hamilton product, add, subtract,
// negate, conjugate, vector rotation, squared norm and norm on Q16.16 data.
// An accepted operand transaction goes through the front queue, the
// product/sum stages and 32 root stages of the fully pipelined back end.
// Throughput: one transaction per cycle unless the back end is stalled.
// Reset (arst_n low, asynchronous) empties the queue and the pipeline.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  qau_pkg::in_t  operand,
	output logic          empty,
	input  logic          pop,
	output qau_pkg::out_t result
);

	// Front hands decoded transactions to the back through a two-entry queue,
	// so a stalled result side never blocks intake until that queue fills.
	logic           head_valid;
	qau_pkg::item_t head;
	logic           take;

	qau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operand    (operand),
		.head_valid (head_valid),
		.head       (head),
		.take       (take)
	);

	// Back end stalls as a whole while the result register is held;
	// its final stage is the result register seen on the ports.
	qau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.take       (take),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
